/* design/pfd_pkg.sv */
`timescale 1ns / 1ps
// Package for the packet FIFO with duplicate detection and range count.
// Holds the command codes, state type, entry and result types and defaults.
// No dependencies.
package pfd_pkg;

   // Default number of entries in the packet store
   localparam int unsigned PFD_DEPTH = 64;

   // Field widths fixed by the interface
   localparam int unsigned SRC_W   = 16;
   localparam int unsigned DST_W   = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned LIMIT_W = 7;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned CMD_W   = 2;

   // Limit register value after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Saturation value of the match counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FWD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CNT = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ADD_WR,
      ST_FWD_RD,
      ST_FWD_CAP,
      ST_DONE
   } pfd_state_type;

   // One stored packet
   typedef struct packed {
      logic [SRC_W-1:0]  src;
      logic [DST_W-1:0]  dst;
      logic [TIME_W-1:0] tim;
   } pfd_entry_type;

   // One result item
   typedef struct packed {
      logic               accepted;
      logic               found;
      logic [SRC_W-1:0]   out_src;
      logic [DST_W-1:0]   out_dst;
      logic [TIME_W-1:0]  out_time;
      logic [COUNT_W-1:0] match_count;
   } pfd_result_type;

endpackage

/* design/pfd_store.sv */
`timescale 1ns / 1ps
// Packet store: one write port, one read port, read data registered.
// Depends on pfd_pkg for the entry type.
module pfd_store #(
   parameter int unsigned DEPTH = pfd_pkg::PFD_DEPTH
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output pfd_pkg::pfd_entry_type     rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  pfd_pkg::pfd_entry_type     wr_data
);
   import pfd_pkg::*;

   pfd_entry_type entry_mem [DEPTH];
   pfd_entry_type rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read: the addressed entry appears in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pfd_ctrl.sv */
`timescale 1ns / 1ps
// Controller: accepts commands, walks live entries through the store read
// port, appends and pops entries, and holds the limit register. Uses pfd_pkg.
module pfd_ctrl #(
   parameter int unsigned DEPTH = pfd_pkg::PFD_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pfd_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pfd_pkg::SRC_W-1:0]     req_src_id,
   input  logic [pfd_pkg::DST_W-1:0]     req_dst_id,
   input  logic [pfd_pkg::TIME_W-1:0]    req_pkt_time,
   input  logic [pfd_pkg::TIME_W-1:0]    req_range_lo,
   input  logic [pfd_pkg::TIME_W-1:0]    req_range_hi,
   // limit register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pfd_pkg::LIMIT_W-1:0]   csr_wdata,
   // store ports
   output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
   input  pfd_pkg::pfd_entry_type        mem_rd_data,
   output logic                          mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
   output pfd_pkg::pfd_entry_type        mem_wr_data,
   // result handoff
   output logic                          res_valid,
   output pfd_pkg::pfd_result_type       res,
   input  logic                          out_free
);
   import pfd_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = OCC_W + 1;
   localparam int unsigned CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

   // Step a pointer with wrap at the store depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   pfd_state_type          state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   pfd_entry_type          key_ff, key_in;
   logic [TIME_W-1:0]      lo_ff, lo_in;
   logic [TIME_W-1:0]      hi_ff, hi_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]       walk_cnt_ff, walk_cnt_in;
   logic                   pend_ff, pend_in;
   logic                   dup_ff, dup_in;
   pfd_result_type         res_ff, res_in;
   logic [LIMIT_W-1:0]     limit_ff;

   logic                   issue;
   logic                   hit_cnt;
   logic [SUM_W-1:0]       tail_sum;
   logic [PTR_W-1:0]       tail_addr;
   logic [CMP_W-1:0]       lim_ext;
   logic [CMP_W-1:0]       eff_lim;
   logic                   evict;

   // Effective limit: zero acts as one, clip at the store depth
   always_comb begin
      lim_ext = CMP_W'(limit_ff);
      if (lim_ext == '0) begin
         eff_lim = CMP_W'(1);
      end else if (lim_ext > CMP_W'(DEPTH)) begin
         eff_lim = CMP_W'(DEPTH);
      end else begin
         eff_lim = lim_ext;
      end
      evict = (CMP_W'(occ_ff) >= eff_lim);
   end

   // Tail slot is head plus occupancy, wrapped once
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(occ_ff);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(DEPTH);
      end
      tail_addr = tail_sum[PTR_W-1:0];
   end

   assign issue   = (walk_cnt_ff != occ_ff);
   assign hit_cnt = (mem_rd_data.dst == key_ff.dst) && (mem_rd_data.tim >= lo_ff)
                    && (mem_rd_data.tim <= hi_ff);

   // Next state and outputs
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      head_in     = head_ff;
      occ_in      = occ_ff;
      rd_ptr_in   = rd_ptr_ff;
      walk_cnt_in = walk_cnt_ff;
      pend_in     = 1'b0;
      dup_in      = dup_ff;
      res_in      = res_ff;
      req_stall   = (state_ff != ST_IDLE);
      mem_wr_en   = 1'b0;
      res_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_cmd;
               key_in.src  = req_src_id;
               key_in.dst  = req_dst_id;
               key_in.tim  = req_pkt_time;
               lo_in       = req_range_lo;
               hi_in       = req_range_hi;
               rd_ptr_in   = head_ff;
               walk_cnt_in = '0;
               dup_in      = 1'b0;
               res_in      = '0;
               case (req_cmd)
                  CMD_ADD: state_in = ST_WALK;
                  CMD_CNT: state_in = ST_WALK;
                  CMD_FWD: state_in = (occ_ff != '0) ? ST_FWD_RD : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            // issue one read a cycle, compare the data in the cycle after
            if (issue) begin
               walk_cnt_in = walk_cnt_ff + 1'b1;
               rd_ptr_in   = ptr_inc(rd_ptr_ff);
            end
            pend_in = issue;
            if (pend_ff) begin
               if (cmd_ff == CMD_ADD && mem_rd_data == key_ff) begin
                  dup_in = 1'b1;
               end
               if (cmd_ff == CMD_CNT && hit_cnt && res_ff.match_count != COUNT_MAX) begin
                  res_in.match_count = res_ff.match_count + 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               if (cmd_ff == CMD_ADD && !dup_ff) begin
                  state_in = ST_ADD_WR;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADD_WR: begin
            // append at the tail, drop the oldest when at the limit
            mem_wr_en       = 1'b1;
            res_in.accepted = 1'b1;
            if (evict) begin
               head_in = ptr_inc(head_ff);
            end else begin
               occ_in = occ_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_FWD_RD: begin
            state_in = ST_FWD_CAP;
         end
         ST_FWD_CAP: begin
            // capture the oldest entry and pop it
            res_in.found    = 1'b1;
            res_in.out_src  = mem_rd_data.src;
            res_in.out_dst  = mem_rd_data.dst;
            res_in.out_time = mem_rd_data.tim;
            head_in         = ptr_inc(head_ff);
            occ_in          = occ_ff - 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready   = 1'b1;
   assign mem_rd_addr = rd_ptr_ff;
   assign mem_wr_addr = tail_addr;
   assign mem_wr_data = key_ff;
   assign res         = res_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Item and walk registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rd_ptr_ff   <= rd_ptr_in;
      walk_cnt_ff <= walk_cnt_in;
      dup_ff      <= dup_in;
      res_ff      <= res_in;
   end

endmodule

/* design/packet_fifo_dedup_range_count.sv */
`timescale 1ns / 1ps
// Bounded packet FIFO with duplicate rejection and destination/time range
// counting. One item is worked on at a time. Add and count walk every live
// entry through the single read port of the entry memory, one entry per
// cycle. A finished result sits in the output register while the next item
// is accepted; while an earlier result is still stalled there, the finished
// one waits and the input stays stalled. The limit register may be written
// at any time the block is idle; the store needs no clearing after reset.
// Depends on pfd_pkg, pfd_store and pfd_ctrl.
module packet_fifo_dedup_range_count #(
   parameter int unsigned DEPTH = pfd_pkg::PFD_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pfd_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pfd_pkg::SRC_W-1:0]     req_src_id,
   input  logic [pfd_pkg::DST_W-1:0]     req_dst_id,
   input  logic [pfd_pkg::TIME_W-1:0]    req_pkt_time,
   input  logic [pfd_pkg::TIME_W-1:0]    req_range_lo,
   input  logic [pfd_pkg::TIME_W-1:0]    req_range_hi,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_found,
   output logic [pfd_pkg::SRC_W-1:0]     rsp_out_src,
   output logic [pfd_pkg::DST_W-1:0]     rsp_out_dst,
   output logic [pfd_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [pfd_pkg::COUNT_W-1:0]   rsp_match_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pfd_pkg::LIMIT_W-1:0]   csr_wdata
);
   import pfd_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);

   logic [PTR_W-1:0]  mem_rd_addr;
   pfd_entry_type     mem_rd_data;
   logic              mem_wr_en;
   logic [PTR_W-1:0]  mem_wr_addr;
   pfd_entry_type     mem_wr_data;
   logic              res_valid;
   pfd_result_type    res;
   logic              out_free;
   logic              rsp_valid_ff;
   pfd_result_type    rsp_ff;

   pfd_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   pfd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_src_id   (req_src_id),
      .req_dst_id   (req_dst_id),
      .req_pkt_time (req_pkt_time),
      .req_range_lo (req_range_lo),
      .req_range_hi (req_range_hi),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .res_valid    (res_valid),
      .res          (res),
      .out_free     (out_free)
   );

   // Output register frees when empty or when its item is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   // Load the result item, hold it while stalled
   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_found       = rsp_ff.found;
   assign rsp_out_src     = rsp_ff.out_src;
   assign rsp_out_dst     = rsp_ff.out_dst;
   assign rsp_out_time    = rsp_ff.out_time;
   assign rsp_match_count = rsp_ff.match_count;

`ifndef NO_ASSERTIONS
   // An accepted item keeps the command side busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command side not busy after an accepted item");

   // A finished result reaches the output register when it is free
   a_result_handoff: assert property (@(posedge clock) disable iff (reset)
      (res_valid && out_free) |=> rsp_valid)
      else $error("finished result not loaded into output register");

   // At most one kind of answer per result item
   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_accepted, rsp_found, (rsp_match_count != '0)}) <= 1))
      else $error("result item carries more than one kind of answer");

   // Packet fields are zero unless a packet was forwarded
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_out_src == '0 && rsp_out_dst == '0 && rsp_out_time == '0))
      else $error("packet fields not zero without a forwarded packet");
`endif

endmodule
